/* hw/rtl/uidq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_pkg
// Shared types, codes and defaults for the unique-ID FIFO queue.
// ----------------------------------------------------------------------------
package uidq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF    = 16;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned PID_W    = 16;
  localparam int unsigned ID_OUT_W = 16;
  localparam int unsigned STAT_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ      = 3'd0,
    FN_DEQ      = 3'd1,
    FN_LIST     = 3'd2,
    FN_LIST_CLR = 3'd3,
    FN_CLEAR    = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_DUP     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_CLEARED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_DEQ,
    ST_LIST,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [ID_OUT_W-1:0] id_out;
    status_e             status;
    logic                last_item;
  } res_t;

endpackage

/* hw/rtl/uidq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface uidq_in_if;
  import uidq_pkg::*;

  logic             valid;
  logic             ready;
  logic [FUNC_W-1:0] func;
  logic [PID_W-1:0]  patient_id;

  modport source (output valid, output func, output patient_id, input ready);
  modport sink   (input valid, input func, input patient_id, output ready);
endinterface

interface uidq_out_if;
  import uidq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_OUT_W-1:0] id_out;
  logic [STAT_W-1:0]   status;
  logic                last_item;

  modport source (output valid, output id_out, output status, output last_item,
                  input ready);
  modport sink   (input valid, input id_out, input status, input last_item,
                  output ready);
endinterface

/* hw/rtl/uidq_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_mem
// Identifier store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uidq_mem #(
  parameter int unsigned DEPTH = uidq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = uidq_pkg::ID_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

/* hw/rtl/uidq_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_seq
// Command sequencer: walks the store through one compare unit, keeps the
// head/tail pointers and entry count, and offers results one at a time.
// ----------------------------------------------------------------------------
module uidq_seq #(
  parameter int unsigned QUEUE_DEPTH = uidq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = uidq_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [uidq_pkg::FUNC_W-1:0]    in_func_i,
  input  logic [uidq_pkg::PID_W-1:0]     in_id_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output uidq_pkg::res_t                 res_o,
  output logic                           mem_wr_en_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_wr_addr_o,
  output logic [ID_WIDTH-1:0]            mem_wr_data_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_rd_addr_o,
  input  logic [ID_WIDTH-1:0]            mem_rd_data_i
);
  import uidq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  state_e               state_q, state_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [PTR_W-1:0]     tail_q, tail_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     k_q, k_d;
  logic [ID_WIDTH-1:0]  id_q, id_d;
  logic                 clr_q, clr_d;
  res_t                 res_q, res_d;

  logic             acc, res_hs, k_end, hit, list_last, full, empty;
  logic [PTR_W-1:0] head_nxt, tail_nxt, rd_ptr_nxt;
  func_e            func_in;

  assign func_in     = func_e'(in_func_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_LIST) || (state_q == ST_RESP);
  assign res_hs      = res_valid_o && res_ready_i;

  // the shared compare unit
  assign hit       = (mem_rd_data_i == id_q);
  assign k_end     = (k_q == count_q);
  assign list_last = ((k_q + CNT_W'(1)) == count_q);
  assign full      = (count_q == CNT_FULL);
  assign empty     = (count_q == '0);

  assign head_nxt   = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
  assign tail_nxt   = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);

  // read address looks one step ahead so read data always matches rd_ptr_q
  assign mem_rd_addr_o = rd_ptr_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (func_in)
            FN_ENQ:               state_d = ST_SRCH;
            FN_DEQ:               state_d = ST_DEQ;
            FN_LIST, FN_LIST_CLR: state_d = empty ? ST_RESP : ST_LIST;
            FN_CLEAR:             state_d = ST_RESP;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_SRCH: begin
        if (k_end || hit) begin
          state_d = ST_RESP;
        end
      end
      ST_DEQ:  state_d = ST_RESP;
      ST_LIST: begin
        if (res_hs && list_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (res_hs) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    rd_ptr_d      = head_q;
    k_d           = k_q;
    id_d          = id_q;
    clr_d         = clr_q;
    res_d         = res_q;
    res_o         = res_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = tail_q;
    mem_wr_data_o = id_q;
    case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (acc) begin
          id_d  = ID_WIDTH'(in_id_i);
          clr_d = (func_in == FN_LIST_CLR);
          case (func_in)
            FN_LIST, FN_LIST_CLR: begin
              res_d = '{id_out: '0, status: STAT_EMPTY, last_item: 1'b1};
            end
            FN_CLEAR: begin
              res_d = '{id_out: '0, status: empty ? STAT_OK : STAT_CLEARED,
                        last_item: 1'b1};
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH: begin
        rd_ptr_d = rd_ptr_q;
        if (!k_end && hit) begin
          res_d = '{id_out: '0, status: STAT_DUP, last_item: 1'b1};
        end else if (k_end) begin
          if (full) begin
            res_d = '{id_out: '0, status: STAT_FULL, last_item: 1'b1};
          end else begin
            mem_wr_en_o = 1'b1;
            tail_d      = tail_nxt;
            count_d     = count_q + CNT_W'(1);
            res_d       = '{id_out: '0, status: STAT_OK, last_item: 1'b1};
          end
        end else begin
          rd_ptr_d = rd_ptr_nxt;
          k_d      = k_q + CNT_W'(1);
        end
      end
      ST_DEQ: begin
        if (empty) begin
          res_d = '{id_out: '0, status: STAT_EMPTY, last_item: 1'b1};
        end else begin
          res_d = '{id_out: ID_OUT_W'(mem_rd_data_i), status: STAT_OK,
                    last_item: 1'b1};
          head_d  = head_nxt;
          count_d = count_q - CNT_W'(1);
        end
      end
      ST_LIST: begin
        rd_ptr_d = rd_ptr_q;
        res_o    = '{id_out: ID_OUT_W'(mem_rd_data_i), status: STAT_OK,
                     last_item: list_last};
        if (res_hs) begin
          if (list_last) begin
            if (clr_q) begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end
          end else begin
            rd_ptr_d = rd_ptr_nxt;
            k_d      = k_q + CNT_W'(1);
          end
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      rd_ptr_q <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    clr_q <= clr_d;
    res_q <= res_d;
  end

endmodule

/* hw/rtl/unique_id_fifo_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_fifo_queue
// Bounded FIFO of identifiers with a duplicate check on enqueue.
// ----------------------------------------------------------------------------
// Commands arrive one item at a time on in_ch and each yields its results
// on out_ch, which has an output register so a new command can be taken
// while the last result waits. All work goes through the single read port
// of the identifier store, one entry per cycle unless the output stalls,
// compared by one shared equality unit. Enqueue walks the stored entries
// with a search step per stored entry, then takes one decision step, one
// result step and the idle accept step; a duplicate ends the search at the
// matching entry. Dequeue and clear go through a single result step, and
// list or list-and-clear give one result per cycle while the output takes
// them (a single empty result when empty); output stalls hold any result
// step. Unknown command codes are dropped. The store needs no clearing
// after reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module unique_id_fifo_queue #(
  parameter int unsigned QUEUE_DEPTH = uidq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = uidq_pkg::ID_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uidq_in_if.sink    in_ch,
  uidq_out_if.source out_ch
);
  import uidq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic                res_valid, res_ready;
  res_t                res;
  logic                mem_wr_en;
  logic [PTR_W-1:0]    mem_wr_addr, mem_rd_addr;
  logic [ID_WIDTH-1:0] mem_wr_data, mem_rd_data;

  // output register
  logic out_vld_q, out_vld_d;
  res_t out_res_q, out_res_d;

  uidq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  uidq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_o    (in_ch.ready),
    .in_func_i     (in_ch.func),
    .in_id_i       (in_ch.patient_id),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  // register takes a new item when empty or being drained this cycle
  assign res_ready = !out_vld_q || out_ch.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    out_res_d = out_res_q;
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
      out_res_d = res;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_ch.valid     = out_vld_q;
  assign out_ch.id_out    = out_res_q.id_out;
  assign out_ch.status    = out_res_q.status;
  assign out_ch.last_item = out_res_q.last_item;

  // no new command while the sequencer still offers a result
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ch.ready)
    else $error("command accepted while a result is pending");

  // a stalled result is held unchanged by the sequencer
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed under stall");

  // error and clear statuses end the command and carry no identifier
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status != STAT_OK) |-> (res.last_item && res.id_out == '0))
    else $error("status result malformed");

  // output register never drops an item it still holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ch.ready) |=> (out_vld_q && $stable(out_res_q)))
    else $error("output item lost under stall");

endmodule

/* tb/uidq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_checker
// Watches both channels of the unique-ID queue, mirrors its contents and
// compares every result against the mirror's prediction.
// ----------------------------------------------------------------------------
module uidq_checker #(
  parameter int unsigned QUEUE_DEPTH = uidq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = uidq_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  logic                          cmd_ready_i,
  input  logic [uidq_pkg::FUNC_W-1:0]   cmd_func_i,
  input  logic [uidq_pkg::PID_W-1:0]    cmd_pid_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [uidq_pkg::ID_OUT_W-1:0] res_id_i,
  input  logic [uidq_pkg::STAT_W-1:0]   res_status_i,
  input  logic                          res_last_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   due_cnt_o
);
  import uidq_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  // mirror of the queue contents
  logic [ID_WIDTH-1:0] mirror_ids [QUEUE_DEPTH];
  int unsigned         head_idx;
  int unsigned         tail_idx;
  int unsigned         num_stored;

  res_t results_due [$];

  function automatic res_t make_res(input logic [ID_OUT_W-1:0] id, input status_e st,
                                    input logic last);
    res_t r;
    r.id_out    = id;
    r.status    = st;
    r.last_item = last;
    return r;
  endfunction

  function automatic void empty_mirror();
    head_idx   = 0;
    tail_idx   = 0;
    num_stored = 0;
  endfunction

  // walk head to tail, one result per entry, or a single empty result when nothing is stored
  function automatic void list_mirror();
    int unsigned k;
    if (num_stored == 0) begin
      results_due.push_back(make_res('0, STAT_EMPTY, 1'b1));
    end else begin
      for (k = 0; k < num_stored; k++) begin
        results_due.push_back(make_res(ID_OUT_W'(mirror_ids[(head_idx + k) % QUEUE_DEPTH]),
                                       STAT_OK, (k + 1 == num_stored)));
      end
    end
  endfunction

  function automatic void apply_queue_cmd(input logic [FUNC_W-1:0] fn,
                                          input logic [PID_W-1:0] pid);
    logic [ID_WIDTH-1:0] id;
    bit                  found;
    int unsigned         k;
    id    = ID_WIDTH'(pid);
    found = 1'b0;
    case (fn)
      FN_ENQ: begin
        for (k = 0; k < num_stored; k++) begin
          if (mirror_ids[(head_idx + k) % QUEUE_DEPTH] == id) found = 1'b1;
        end
        // duplicate wins over full
        if (found) begin
          results_due.push_back(make_res('0, STAT_DUP, 1'b1));
        end else if (num_stored >= QUEUE_DEPTH) begin
          results_due.push_back(make_res('0, STAT_FULL, 1'b1));
        end else begin
          mirror_ids[tail_idx] = id;
          tail_idx             = (tail_idx + 1) % QUEUE_DEPTH;
          num_stored++;
          results_due.push_back(make_res('0, STAT_OK, 1'b1));
        end
      end
      FN_DEQ: begin
        if (num_stored == 0) begin
          results_due.push_back(make_res('0, STAT_EMPTY, 1'b1));
        end else begin
          results_due.push_back(make_res(ID_OUT_W'(mirror_ids[head_idx]), STAT_OK, 1'b1));
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          num_stored--;
        end
      end
      FN_LIST: list_mirror();
      FN_LIST_CLR: begin
        list_mirror();
        empty_mirror();
      end
      FN_CLEAR: begin
        results_due.push_back(make_res('0, (num_stored != 0) ? STAT_CLEARED : STAT_OK, 1'b1));
        empty_mirror();
      end
      default: ;  // undefined codes are dropped
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : mon_p
    res_t want;
    if (!rst_ni) begin
      empty_mirror();
      results_due.delete();
      fail_cnt_o = 0;
      due_cnt_o  = 0;
    end else begin
      if (cmd_valid_i && cmd_ready_i) apply_queue_cmd(cmd_func_i, cmd_pid_i);
      if (res_valid_i && res_ready_i) begin
        if (results_due.size() == 0) begin
          if (fail_cnt_o < MAX_REPORTS)
            $display("%0t: unexpected result id %h status %0d last %0b", $realtime,
                     res_id_i, res_status_i, res_last_i);
          fail_cnt_o++;
        end else begin
          want = results_due.pop_front();
          if (res_id_i !== want.id_out || res_status_i !== want.status ||
              res_last_i !== want.last_item) begin
            if (fail_cnt_o < MAX_REPORTS)
              $display("%0t: mismatch id %h/%h status %0d/%0d last %0b/%0b (exp/act)",
                       $realtime, want.id_out, res_id_i, want.status, res_status_i,
                       want.last_item, res_last_i);
            fail_cnt_o++;
          end
        end
      end
      due_cnt_o = results_due.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the unique-ID FIFO queue.
// ----------------------------------------------------------------------------
// A directed opener hits the empty cases, extreme IDs, duplicates, every
// command and the undefined codes. Random phases follow: fill-to-capacity
// runs (duplicate-while-full, full, then list or drain) mixed with loose
// commands drawn from a small ID pool so duplicates keep turning up. Both
// sides insert random gaps; some phases run gapless. One phase holds the
// result side off for a long stretch so the queue backs up into the input.
// uidq_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import uidq_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned MAX_GAP       = 10;
  localparam int unsigned ITEM_TARGET   = 410;
  localparam int unsigned CMDS_PER_PASS = 30;
  localparam int unsigned HOLD_CYCLES   = 400;
  // a full list, plus margin, covers any work still in flight
  localparam int unsigned SETTLE_CYCLES = 2 * QUEUE_DEPTH_DEF + 4;
  localparam int unsigned TIMEOUT_CYCLES = 800_000;

  logic clk;
  logic rst_n;

  uidq_in_if  in_ch ();
  uidq_out_if out_ch ();

  int unsigned fail_cnt;
  int unsigned due_cnt;
  int unsigned sent_cnt;   // commands with a defined code only

  // idle knobs, flipped per phase
  bit src_idle;
  bit snk_idle;
  bit hold_req;

  unique_id_fifo_queue u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  uidq_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_valid_i  (in_ch.valid),
    .cmd_ready_i  (in_ch.ready),
    .cmd_func_i   (in_ch.func),
    .cmd_pid_i    (in_ch.patient_id),
    .res_valid_i  (out_ch.valid),
    .res_ready_i  (out_ch.ready),
    .res_id_i     (out_ch.id_out),
    .res_status_i (out_ch.status),
    .res_last_i   (out_ch.last_item),
    .fail_cnt_o   (fail_cnt),
    .due_cnt_o    (due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // single reset pulse at the start
  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: random stall per result; a hold request parks ready low
  // for HOLD_CYCLES, counted here.
  initial begin : sink_p
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one command and wait for the handshake. Valid stays high after
  // the accept; it only drops when a gap is drawn or a phase drains.
  task automatic issue_cmd(input logic [FUNC_W-1:0] fn, input logic [PID_W-1:0] pid);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= fn;
    in_ch.patient_id <= pid;
    do @(posedge clk); while (!in_ch.ready);
    if (fn <= FN_CLEAR) sent_cnt++;
  endtask

  // Stop offering, wait out every outstanding result, then let the block
  // settle. The extra edge first lets the checker log the last accept.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (due_cnt == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Half the time a small pool (0000, 1111, ... FFFF) to force duplicates.
  function automatic logic [PID_W-1:0] pick_id();
    if ($urandom_range(0, 1) == 0) return PID_W'(16'h1111 * $urandom_range(0, 15));
    return PID_W'($urandom);
  endfunction

  task automatic random_cmd();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      issue_cmd(FN_ENQ, pick_id());
    else if (pick < 70) issue_cmd(FN_DEQ, PID_W'($urandom));
    else if (pick < 80) issue_cmd(FN_LIST, PID_W'($urandom));
    else if (pick < 86) issue_cmd(FN_LIST_CLR, PID_W'($urandom));
    else if (pick < 93) issue_cmd(FN_CLEAR, PID_W'($urandom));
    else issue_cmd(FUNC_W'($urandom_range(FN_CLEAR + 1, 2**FUNC_W - 1)), PID_W'($urandom));
  endtask

  // Empty the queue, fill it to the brim, poke it with a duplicate and an
  // overflow, then read it back one way or another.
  task automatic fill_to_capacity();
    logic [PID_W-1:0] first_id;
    issue_cmd(($urandom_range(0, 1) == 0) ? FN_CLEAR : FN_LIST_CLR, PID_W'($urandom));
    first_id = PID_W'($urandom);
    issue_cmd(FN_ENQ, first_id);
    repeat (QUEUE_DEPTH_DEF - 1) issue_cmd(FN_ENQ, PID_W'($urandom));
    issue_cmd(FN_ENQ, first_id);           // duplicate while full
    issue_cmd(FN_ENQ, PID_W'($urandom));   // overflow
    case ($urandom_range(0, 2))
      0:       issue_cmd(FN_LIST, PID_W'($urandom));
      1:       issue_cmd(FN_LIST_CLR, PID_W'($urandom));
      default: repeat ($urandom_range(1, QUEUE_DEPTH_DEF)) issue_cmd(FN_DEQ, PID_W'($urandom));
    endcase
  endtask

  initial begin : stim_p
    int unsigned phase;
    int unsigned code;
    in_ch.valid      = 1'b0;
    in_ch.func       = FN_ENQ;
    in_ch.patient_id = '0;
    sent_cnt         = 0;
    src_idle         = 1'b1;
    snk_idle         = 1'b1;
    hold_req         = 1'b0;
    wait (rst_n);
    @(posedge clk);

    // --- directed opener ---
    // everything on an empty queue
    issue_cmd(FN_DEQ, 16'hFFFF);
    issue_cmd(FN_LIST, '0);
    issue_cmd(FN_LIST_CLR, 16'hFFFF);
    issue_cmd(FN_CLEAR, '0);           // nothing waited: plain ok
    // extreme IDs and duplicates of them
    issue_cmd(FN_ENQ, 16'h0000);
    issue_cmd(FN_ENQ, 16'hFFFF);
    issue_cmd(FN_ENQ, 16'hFFFF);
    issue_cmd(FN_ENQ, 16'h0000);
    issue_cmd(FN_ENQ, 16'h5555);
    issue_cmd(FN_ENQ, 16'hAAAA);
    issue_cmd(FN_LIST, '0);
    issue_cmd(FN_DEQ, '0);
    // undefined codes leave no trace
    for (code = FN_CLEAR + 1; code < 2**FUNC_W; code++)
      issue_cmd(FUNC_W'(code), 16'hFFFF);
    issue_cmd(FN_LIST_CLR, '0);
    issue_cmd(FN_DEQ, '0);
    issue_cmd(FN_ENQ, 16'h1234);
    issue_cmd(FN_CLEAR, '0);           // entries waited
    issue_cmd(FN_LIST, '0);
    drain_results();

    // --- random phases ---
    phase = 0;
    while (sent_cnt < ITEM_TARGET) begin
      case (phase % 4)
        0: begin src_idle = 1'b1; snk_idle = 1'b1; end
        1: begin src_idle = 1'b0; snk_idle = 1'b0; end
        2: begin src_idle = 1'b1; snk_idle = 1'b0; end
        default: begin src_idle = 1'b0; snk_idle = 1'b1; end
      endcase
      if (phase == 0) fill_to_capacity();
      // backpressure: results parked, sender keeps offering until stalled
      if (phase == 1) begin
        hold_req = 1'b1;
        repeat (12) random_cmd();
      end
      repeat (CMDS_PER_PASS) begin
        if ($urandom_range(0, 7) == 0) fill_to_capacity();
        else random_cmd();
      end
      drain_results();
      phase++;
    end

    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
